// ===== hw/rtl/pwm_pkg.sv =====
// shared constants, types and codes for the permutation window match block
`timescale 1ns / 1ps

package pwm_pkg;

	// sizing of the pattern store and the letter alphabet
	localparam int MAX_PATTERN = 64;
	localparam int ALPHABET    = 26;

	// derived widths
	localparam int PTR_W    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CNT_W    = $clog2(MAX_PATTERN + 1);
	localparam int LETTER_W = 5;
	localparam int FUNC_W   = 2;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 8;
	localparam int OUT_FIELDS  = 3;

	// item selector codes; the spare code changes nothing
	typedef enum logic [FUNC_W-1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_PATTERN = 2'd1,
		FUNC_TEXT    = 2'd2,
		FUNC_SPARE   = 2'd3
	} func_t;

	// control from the window logic to the ring memory
	typedef struct packed {
		logic                we;
		logic [PTR_W-1:0]    waddr;
		logic [LETTER_W-1:0] wdata;
		logic [PTR_W-1:0]    raddr;
	} ring_ctl_t;

endpackage

// ===== hw/rtl/permutation_window_match.sv =====
// top level: sliding window anagram search over a stream of letter codes
// result: the flags of each accepted transaction are registered into the output buffer
// throughput: one item per cycle while the skid entry is free; histogram update and the full count compare finish
// in the same cycle, and a two-entry output buffer keeps s_tready high while one result waits
// reset: histograms, pointers, lengths and flags clear at once; the ring needs no clearing
`timescale 1ns / 1ps

module permutation_window_match
	import pwm_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // letter[4:0], zero pad
	input  logic [FUNC_W-1:0]      s_tuser,   // func[1:0]
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // window_match, found, pattern_overflow, zero pad
);

	// histogram and window state
	logic [CNT_W-1:0] pat_cnt_q [ALPHABET];
	logic [CNT_W-1:0] win_cnt_q [ALPHABET];
	logic [PTR_W-1:0] ptr_q;
	logic [CNT_W-1:0] plen_q;
	logic [CNT_W-1:0] seen_q;
	logic             found_q;
	logic             ovf_q;

	// next state
	logic [CNT_W-1:0] pat_cnt_d [ALPHABET];
	logic [CNT_W-1:0] win_cnt_d [ALPHABET];
	logic [PTR_W-1:0] ptr_d;
	logic [CNT_W-1:0] plen_d;
	logic [CNT_W-1:0] seen_d;
	logic             found_d;
	logic             ovf_d;
	logic             match_d;

	// output buffer
	logic                  out_valid_q;
	logic [OUT_FIELDS-1:0] out_data_q;
	logic                  skid_valid_q;
	logic [OUT_FIELDS-1:0] skid_data_q;

	logic                  acc;
	logic                  pop;
	func_t                 func;
	logic [LETTER_W-1:0]   letter;
	logic                  letter_ok;
	logic [LETTER_W-1:0]   old_letter;
	logic                  full_before;
	logic [CNT_W-1:0]      ptr_inc;
	logic                  all_equal;
	logic [OUT_FIELDS-1:0] res;
	ring_ctl_t             ring_ctl;

	assign acc       = s_tvalid && s_tready;
	assign pop       = m_tvalid && m_tready;
	assign func      = func_t'(s_tuser);
	assign letter    = s_tdata[LETTER_W-1:0];
	assign letter_ok = 32'(letter) < ALPHABET;

	pwm_ring u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ring_ctl),
		.rdata  (old_letter)
	);

	assign full_before = seen_q >= plen_q;
	assign ptr_inc     = CNT_W'(ptr_q) + CNT_W'(1);

	// state update for one accepted item
	always_comb begin
		pat_cnt_d = pat_cnt_q;
		win_cnt_d = win_cnt_q;
		ptr_d     = ptr_q;
		plen_d    = plen_q;
		seen_d    = seen_q;
		found_d   = found_q;
		ovf_d     = ovf_q;
		match_d   = 1'b0;
		all_equal = 1'b1;
		ring_ctl.we    = 1'b0;
		ring_ctl.waddr = ptr_q;
		ring_ctl.wdata = letter;
		if (acc) begin
			case (func)
				FUNC_CLEAR: begin
					for (int k = 0; k < ALPHABET; k++) begin
						pat_cnt_d[k] = '0;
						win_cnt_d[k] = '0;
					end
					ptr_d   = '0;
					plen_d  = '0;
					seen_d  = '0;
					found_d = 1'b0;
					ovf_d   = 1'b0;
				end
				FUNC_PATTERN: begin
					if (letter_ok) begin
						if (32'(plen_q) < MAX_PATTERN) begin
							for (int k = 0; k < ALPHABET; k++) begin
								if (32'(letter) == k) begin
									pat_cnt_d[k] = pat_cnt_q[k] + CNT_W'(1);
								end
							end
							plen_d = plen_q + CNT_W'(1);
						end else begin
							ovf_d = 1'b1;
						end
						// restart the text window
						for (int k = 0; k < ALPHABET; k++) begin
							win_cnt_d[k] = '0;
						end
						ptr_d  = '0;
						seen_d = '0;
					end
				end
				FUNC_TEXT: begin
					if (letter_ok) begin
						if (plen_q == '0) begin
							match_d = 1'b1;
						end else begin
							// drop the leaving letter once full, add the new one
							for (int k = 0; k < ALPHABET; k++) begin
								if (full_before && (32'(old_letter) == k) &&
								    (win_cnt_d[k] != '0)) begin
									win_cnt_d[k] = win_cnt_d[k] - CNT_W'(1);
								end
								if (32'(letter) == k) begin
									win_cnt_d[k] = win_cnt_d[k] + CNT_W'(1);
								end
							end
							if (!full_before) begin
								seen_d = seen_q + CNT_W'(1);
							end
							ring_ctl.we = 1'b1;
							if (ptr_inc >= plen_q) begin
								ptr_d = '0;
							end else begin
								ptr_d = ptr_inc[PTR_W-1:0];
							end
							// parallel compare of all counts
							for (int k = 0; k < ALPHABET; k++) begin
								if (pat_cnt_q[k] != win_cnt_d[k]) begin
									all_equal = 1'b0;
								end
							end
							match_d = (seen_d >= plen_q) && all_equal;
						end
						if (match_d) begin
							found_d = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
		// prefetch the entry the next text item will replace
		ring_ctl.raddr = ptr_d;
	end

	assign res = {ovf_d, found_d, match_d};

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ALPHABET; k++) begin
				pat_cnt_q[k] <= '0;
				win_cnt_q[k] <= '0;
			end
			ptr_q   <= '0;
			plen_q  <= '0;
			seen_q  <= '0;
			found_q <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			pat_cnt_q <= pat_cnt_d;
			win_cnt_q <= win_cnt_d;
			ptr_q     <= ptr_d;
			plen_q    <= plen_d;
			seen_q    <= seen_d;
			found_q   <= found_d;
			ovf_q     <= ovf_d;
		end
	end

	// two-entry output buffer: result register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= acc;
				end
			end else if (acc) begin
				if (out_valid_q) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end
		end
	end

	// output buffer payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (acc) begin
				out_data_q <= res;
			end
		end else if (acc) begin
			if (out_valid_q) begin
				skid_data_q <= res;
			end else begin
				out_data_q <= res;
			end
		end
	end

	assign s_tready = !skid_valid_q;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS){1'b0}}, out_data_q};

endmodule

// ===== hw/rtl/pwm_ring.sv =====
// window ring memory with registered read and write-to-read bypass
`timescale 1ns / 1ps

module pwm_ring
	import pwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ring_ctl_t           ctl,
	output logic [LETTER_W-1:0] rdata
);

	logic [LETTER_W-1:0] mem [MAX_PATTERN];
	logic [LETTER_W-1:0] rdata_q;
	logic [LETTER_W-1:0] byp_data_q;
	logic                byp_q;

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= ctl.wdata;
		end
		rdata_q    <= mem[ctl.raddr];
		byp_data_q <= ctl.wdata;
	end

	// remember when the read hit the entry written in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else begin
			byp_q <= ctl.we && (ctl.waddr == ctl.raddr);
		end
	end

	assign rdata = byp_q ? byp_data_q : rdata_q;

endmodule

// ===== bench/permutation_window_match_tb.sv =====
// testbench for the permutation window match block: directed and random letter streams
`timescale 1ns / 1ps

module permutation_window_match_tb
	import pwm_pkg::*;
();

	localparam int HALF_PERIOD    = 10;
	localparam int HOLD_CYCLES    = 300;
	// worst correct gap: the long hold-off plus a long random stall, taken several times over
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int ITEMS_PER_PHASE = 210;

	// tracks the anagram search state and the flags each transaction should return
	class anagram_tracker;
		bit [CNT_W:0]      pat_hist [ALPHABET];
		bit [CNT_W:0]      win_hist [ALPHABET];
		bit [LETTER_W-1:0] ring     [MAX_PATTERN];
		int unsigned       ring_pos;
		int unsigned       pat_len;
		int unsigned       text_seen;
		bit                found;
		bit                overflow;
		// bit 0 window_match, bit 1 found, bit 2 pattern_overflow
		bit [2:0]          pending_flags [$];
		int unsigned       errors;
		int unsigned       match_count;
		int unsigned       overflow_count;

		function new();
			errors = 0;
			match_count = 0;
			overflow_count = 0;
			clear_all();
		endfunction

		function void restart_window();
			for (int k = 0; k < ALPHABET; k++)
				win_hist[k] = '0;
			ring_pos = 0;
			text_seen = 0;
		endfunction

		function void clear_all();
			for (int k = 0; k < ALPHABET; k++)
				pat_hist[k] = '0;
			restart_window();
			pat_len = 0;
			found = 1'b0;
			overflow = 1'b0;
		endfunction

		// work out the flags for one accepted transaction
		function void take_item(logic [FUNC_W-1:0] fn, logic [LETTER_W-1:0] sym);
			bit                hit;
			int unsigned       pos;
			bit [LETTER_W-1:0] old;
			hit = 1'b0;
			if (fn == FUNC_CLEAR) begin
				clear_all();
			end else if (fn == FUNC_PATTERN) begin
				if (sym < ALPHABET) begin
					if (pat_len < MAX_PATTERN) begin
						pat_hist[sym]++;
						pat_len++;
					end else begin
						overflow = 1'b1;
					end
					restart_window();
				end
			end else if (fn == FUNC_TEXT) begin
				if (sym < ALPHABET) begin
					if (pat_len == 0) begin
						hit = 1'b1;
					end else begin
						pos = ring_pos % MAX_PATTERN;
						// full window: the oldest letter leaves
						if (text_seen >= pat_len) begin
							old = ring[pos];
							if (old < ALPHABET && win_hist[old] > 0)
								win_hist[old]--;
						end else begin
							text_seen++;
						end
						ring[pos] = sym;
						win_hist[sym]++;
						pos++;
						if (pos >= pat_len)
							pos = 0;
						ring_pos = pos;
						if (text_seen >= pat_len) begin
							hit = 1'b1;
							for (int k = 0; k < ALPHABET; k++)
								if (pat_hist[k] != win_hist[k])
									hit = 1'b0;
						end
					end
					if (hit)
						found = 1'b1;
				end
			end
			if (hit)
				match_count++;
			if (overflow)
				overflow_count++;
			pending_flags.push_back({overflow, found, hit});
		endfunction

		// compare one result transaction with the oldest expectation
		function void check_result(logic [OUT_TDATA_W-1:0] data);
			bit [2:0] want;
			string    label;
			if (pending_flags.size() == 0) begin
				$display("%0t: unexpected result, expected none got %b", $time, data[2:0]);
				errors++;
				return;
			end
			want = pending_flags.pop_front();
			for (int i = 0; i < 3; i++) begin
				if (want[i] !== data[i]) begin
					case (i)
						0: label = "window_match";
						1: label = "found";
						default: label = "pattern_overflow";
					endcase
					$display("%0t: %s mismatch, expected %0d got %0d", $time, label,
						want[i], data[i]);
					errors++;
				end
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic [FUNC_W-1:0]      s_tuser;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;

	anagram_tracker tracker;
	int unsigned    send_idle_pct;
	int unsigned    recv_stall_pct;
	bit             hold_req;
	int unsigned    hold_left;
	int unsigned    quiet_cycles;
	int unsigned    items_sent;

	permutation_window_match u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// clock
	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	// result side: random stalls, plus one long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			m_tready = 1'b0;
			hold_left--;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			m_tready = 1'b0;
		end else begin
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			tracker.check_result(m_tdata);
	end

	// watchdog on cycles with no transaction on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// offer one item and wait for its transaction
	task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [LETTER_W-1:0] sym);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser  = fn;
		s_tdata  = {{(IN_TDATA_W-LETTER_W){1'b0}}, sym};
		do @(posedge clk); while (!s_tready);
		tracker.take_item(fn, sym);
		items_sent++;
	endtask

	// one search job: optional clear, a pattern, then text with planted permutations;
	// force_len < 0 picks a random pattern length or, now and then, a noise burst instead
	task automatic run_scenario(input int force_len);
		int                kind;
		int                plen;
		int                tlen;
		int                sent;
		int                lo;
		int                span;
		int                r;
		int                j;
		bit [LETTER_W-1:0] pat [$];
		bit [LETTER_W-1:0] perm [$];
		bit [LETTER_W-1:0] tmp;
		kind = $urandom_range(99);
		// noise burst of arbitrary selectors and codes
		if (force_len < 0 && kind < 8) begin
			repeat ($urandom_range(4, 12))
				send_item(FUNC_W'($urandom_range(3)), LETTER_W'($urandom_range(31)));
			return;
		end
		// mostly start clean, sometimes extend the current pattern
		if (force_len >= 0 || $urandom_range(9) != 0)
			send_item(FUNC_CLEAR, LETTER_W'($urandom_range(31)));
		if (force_len >= 0) begin
			plen = force_len;
		end else begin
			r = $urandom_range(99);
			if (r < 8)
				plen = 0;
			else if (r < 84)
				plen = $urandom_range(1, 6);
			else if (r < 95)
				plen = $urandom_range(7, 20);
			else
				plen = $urandom_range(MAX_PATTERN - 4, MAX_PATTERN + 4);
		end
		// a narrow letter range makes matches frequent
		span = $urandom_range(1, 7);
		lo = $urandom_range(ALPHABET - 1 - span);
		for (int i = 0; i < plen; i++) begin
			tmp = LETTER_W'(lo + $urandom_range(span));
			if (pat.size() < MAX_PATTERN)
				pat.push_back(tmp);
			send_item(FUNC_PATTERN, tmp);
			if ($urandom_range(99) < 4)
				send_item(FUNC_PATTERN, LETTER_W'($urandom_range(ALPHABET, 31)));
		end
		tlen = (plen > 20) ? plen + $urandom_range(5, 40) : $urandom_range(8, 30);
		sent = 0;
		while (sent < tlen) begin
			r = $urandom_range(99);
			if (r < 25 && pat.size() > 0) begin
				// plant a shuffled copy of the pattern
				perm = pat;
				for (int i = perm.size() - 1; i > 0; i--) begin
					j = $urandom_range(i);
					tmp = perm[i];
					perm[i] = perm[j];
					perm[j] = tmp;
				end
				foreach (perm[i])
					send_item(FUNC_TEXT, perm[i]);
				sent += perm.size();
			end else if (r < 27) begin
				send_item(FUNC_TEXT, LETTER_W'($urandom_range(ALPHABET, 31)));
				sent++;
			end else if (r < 29) begin
				send_item(FUNC_SPARE, LETTER_W'($urandom_range(31)));
				sent++;
			end else if (r < 31) begin
				// pattern letter mid-text restarts the window
				tmp = LETTER_W'(lo + $urandom_range(span));
				if (pat.size() < MAX_PATTERN)
					pat.push_back(tmp);
				send_item(FUNC_PATTERN, tmp);
				sent++;
			end else if (r < 90) begin
				send_item(FUNC_TEXT, LETTER_W'(lo + $urandom_range(span)));
				sent++;
			end else begin
				send_item(FUNC_TEXT, LETTER_W'($urandom_range(ALPHABET - 1)));
				sent++;
			end
		end
	endtask

	// main sequence
	initial begin
		tracker = new();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet_cycles = 0;
		items_sent = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty pattern, ignored codes, unused selector, clear
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_TEXT, 5'd31);
		send_item(FUNC_TEXT, 5'd26);
		send_item(FUNC_SPARE, 5'd31);
		send_item(FUNC_CLEAR, 5'd31);
		// pattern abc with an ignored pattern code, then sliding matches
		send_item(FUNC_PATTERN, 5'd0);
		send_item(FUNC_PATTERN, 5'd1);
		send_item(FUNC_PATTERN, 5'd26);
		send_item(FUNC_PATTERN, 5'd2);
		send_item(FUNC_TEXT, 5'd2);
		send_item(FUNC_TEXT, 5'd1);
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_TEXT, 5'd3);
		send_item(FUNC_TEXT, 5'd1);
		send_item(FUNC_TEXT, 5'd2);
		send_item(FUNC_TEXT, 5'd0);
		// pattern letter after text restarts the window, found stays
		send_item(FUNC_PATTERN, 5'd25);
		send_item(FUNC_TEXT, 5'd25);
		send_item(FUNC_TEXT, 5'd0);
		send_item(FUNC_TEXT, 5'd1);
		send_item(FUNC_TEXT, 5'd2);
		send_item(FUNC_CLEAR, 5'd0);
		send_item(FUNC_TEXT, 5'd25);
		send_item(FUNC_SPARE, 5'd0);

		// random phases: none, sender idle, receiver stalls, both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
				default: begin send_idle_pct = 25; recv_stall_pct = 25; end
			endcase
			if (ph == 0) begin
				// long hold-off so the block fills and stalls its input
				hold_req = 1'b1;
				run_scenario(MAX_PATTERN + 2);
			end
			while (items_sent < 25 + (ph + 1) * ITEMS_PER_PHASE)
				run_scenario(-1);
		end
		@(negedge clk);
		s_tvalid = 1'b0;

		// drain
		while (tracker.pending_flags.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("covered %0d items over four handshake phases, %0d matching windows,",
			items_sent, tracker.match_count);
		$display("%0d results with the overflow flag set, %0d mismatches",
			tracker.overflow_count, tracker.errors);
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
